### hdl/mwsl_pkg.sv
// Shared types, widths and constants for the mecanum wheel speed limiter.
`default_nettype none
package mwsl_pkg;

  localparam int WHEELS    = 4;
  localparam int IN_W      = 16;
  localparam int CFG_W     = 16;
  localparam int LIM_W     = 15;
  localparam int TMAG_W    = 32;
  localparam int PROD_W    = 48;
  localparam int MAG_W     = 30;
  localparam int LNUM_W    = 46;
  localparam int MIX_SCALE = 1000;
  localparam int GAIN_DIV  = 256000;
  localparam int ROUND_HALF = GAIN_DIV / 2;

  // The gain divisor is 125 << 11: a shift, then a reciprocal multiply for the 125.
  // The reciprocal is exact for every dividend below 2^37.
  localparam int GAIN_SHR    = 11;
  localparam int RECIP_W     = 38;
  localparam int RECIP_SPLIT = 19;
  localparam int RECIP_SHR   = 44;
  localparam logic [RECIP_W-1:0] RECIP_125 = 38'd140737488356;
  localparam int PART_W = PROD_W - GAIN_SHR + RECIP_SPLIT;
  localparam int QSUM_W = PART_W + RECIP_SPLIT;

  localparam logic [CFG_W-1:0] SPEED_GAIN_RST = 16'd9400;
  localparam logic [CFG_W-1:0] LEVER_ARM_RST  = 16'd440;
  localparam logic [LIM_W-1:0] CMD_LIMIT_RST  = 15'd24576;

  typedef enum logic [1:0] {
    CFG_SPEED_GAIN = 2'd0,
    CFG_LEVER_ARM  = 2'd1,
    CFG_CMD_LIMIT  = 2'd2
  } cfg_idx_e;

  // Wheel value in sign-magnitude form.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } wheel_t;

  localparam int WHL_W = $bits(wheel_t);

  // Wheel served by divider lane "lane" when wheel "idx" is the one checked.
  function automatic logic [1:0] other_wheel(input int idx, input int lane);
    logic [1:0] res;
    res = (lane < idx) ? 2'(lane) : 2'(lane + 1);
    return res;
  endfunction

endpackage
`default_nettype wire

### hdl/mwsl_mix.sv
// Wheel mixing, magnitude, gain multiply and gain scaling stages.
`default_nettype none
module mwsl_mix (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           en_i,
  input  logic                                           valid_i,
  input  logic signed [mwsl_pkg::IN_W-1:0]               forward_speed_i,
  input  logic signed [mwsl_pkg::IN_W-1:0]               side_speed_i,
  input  logic signed [mwsl_pkg::IN_W-1:0]               turn_rate_i,
  input  logic [mwsl_pkg::CFG_W-1:0]                     speed_gain_i,
  input  logic [mwsl_pkg::CFG_W-1:0]                     lever_arm_i,
  output logic                                           valid_o,
  output logic [mwsl_pkg::WHEELS-1:0]                    neg_o,
  output logic [mwsl_pkg::WHEELS-1:0][mwsl_pkg::MAG_W-1:0] quo_o
);
  import mwsl_pkg::*;

  localparam int NSTG = 7;
  localparam logic signed [33:0] KMIX = 34'(MIX_SCALE);

  logic [NSTG-1:0] valid_q;

  logic signed [16:0] sum_q, dif_q;
  logic signed [32:0] rot_q;
  logic signed [33:0] sum_x, dif_x, rot_x;
  logic signed [WHEELS-1:0][33:0] t_q;
  logic [WHEELS-1:0][TMAG_W-1:0] mag_q;
  logic [WHEELS-1:0] neg_c_q, neg_d_q, neg_e_q, neg_f_q, neg_g_q;
  logic [WHEELS-1:0][PROD_W-1:0] prod_q, num_q;
  logic [WHEELS-1:0][PART_W-1:0] plo_q, phi_q;
  logic [WHEELS-1:0][MAG_W-1:0] quo_q;

  assign sum_x = 34'(sum_q);
  assign dif_x = 34'(dif_q);
  assign rot_x = 34'(rot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= 17'(forward_speed_i) + 17'(side_speed_i);
      dif_q <= 17'(forward_speed_i) - 17'(side_speed_i);
      rot_q <= $signed({1'b0, lever_arm_i}) * turn_rate_i;

      t_q[0] <= sum_x * KMIX + rot_x;
      t_q[1] <= dif_x * KMIX - rot_x;
      t_q[2] <= dif_x * KMIX + rot_x;
      t_q[3] <= sum_x * KMIX - rot_x;

      for (int i = 0; i < WHEELS; i++) begin
        neg_c_q[i] <= t_q[i][33];
        mag_q[i]   <= t_q[i][33] ? TMAG_W'(-t_q[i]) : TMAG_W'(t_q[i]);
        prod_q[i]  <= PROD_W'(mag_q[i]) * PROD_W'(speed_gain_i);
        num_q[i]   <= prod_q[i] + PROD_W'(ROUND_HALF);
        // The reciprocal multiply is split in two halves of the constant.
        plo_q[i]   <= PART_W'(num_q[i][PROD_W-1:GAIN_SHR])
                      * PART_W'(RECIP_125[RECIP_SPLIT-1:0]);
        phi_q[i]   <= PART_W'(num_q[i][PROD_W-1:GAIN_SHR])
                      * PART_W'(RECIP_125[RECIP_W-1:RECIP_SPLIT]);
        quo_q[i]   <= MAG_W'(((QSUM_W'(phi_q[i]) << RECIP_SPLIT) + QSUM_W'(plo_q[i]))
                             >> RECIP_SHR);
      end
      neg_d_q <= neg_c_q;
      neg_e_q <= neg_d_q;
      neg_f_q <= neg_e_q;
      neg_g_q <= neg_f_q;
    end
  end

  assign valid_o = valid_q[NSTG-1];
  assign neg_o   = neg_g_q;
  assign quo_o   = quo_q;

endmodule
`default_nettype wire

### hdl/mwsl_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
`default_nettype none
module mwsl_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 18,
  parameter int Q_W   = 30,
  parameter int LANES = 4,
  parameter int TAG_W = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [LANES-1:0][NUM_W-1:0]      num_i,
  input  logic [LANES-1:0][DEN_W-1:0]      den_i,
  input  logic [TAG_W-1:0]                 tag_i,
  output logic                             valid_o,
  output logic [LANES-1:0][Q_W-1:0]        quo_o,
  output logic [TAG_W-1:0]                 tag_o
);

  localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [Q_W-1:0]                 valid_q;
  logic [LANES-1:0][NUM_W-1:0]    rem_q [Q_W];
  logic [LANES-1:0][DEN_W-1:0]    den_q [Q_W];
  logic [LANES-1:0][Q_W-1:0]      quo_q [Q_W];
  logic [TAG_W-1:0]               tag_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int Bit = Q_W - 1 - s;
    logic [LANES-1:0][NUM_W-1:0] rem_in, rem_d;
    logic [LANES-1:0][DEN_W-1:0] den_in;
    logic [LANES-1:0][Q_W-1:0]   quo_in, quo_d;
    logic [TAG_W-1:0]            tag_in;
    logic                        vld_in;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign tag_in = tag_q[s-1];
      assign vld_in = valid_q[s-1];
    end

    always_comb begin
      logic [CMP_W-1:0] cand;
      logic             ge;
      for (int l = 0; l < LANES; l++) begin
        cand     = CMP_W'(den_in[l]) << Bit;
        ge       = CMP_W'(rem_in[l]) >= cand;
        rem_d[l] = ge ? rem_in[l] - cand[NUM_W-1:0] : rem_in[l];
        quo_d[l] = {quo_in[l][Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
        quo_q[s] <= quo_d;
        tag_q[s] <= tag_in;
      end
    end
  end

  assign valid_o = valid_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign tag_o   = tag_q[Q_W-1];

endmodule
`default_nettype wire

### hdl/mwsl_limit.sv
// One wheel check: if that wheel is over the limit, clamps it and rescales the other three.
`default_nettype none
module mwsl_limit #(
  parameter int IDX = 0
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      valid_i,
  input  mwsl_pkg::wheel_t [mwsl_pkg::WHEELS-1:0]   wheels_i,
  input  logic [mwsl_pkg::LIM_W-1:0]                lim_i,
  output logic                                      valid_o,
  output mwsl_pkg::wheel_t [mwsl_pkg::WHEELS-1:0]   wheels_o
);
  import mwsl_pkg::*;

  localparam int LANES = WHEELS - 1;
  localparam int TAG_W = 1 + WHEELS * WHL_W;

  logic [1:0]                   valid_q;
  logic                         flag1_q, flag2_q;
  wheel_t [WHEELS-1:0]          w1_q, w2_q;
  logic [MAG_W-1:0]             den1_q;
  logic [LANES-1:0][MAG_W-1:0]  den2_q;
  logic [LANES-1:0][LNUM_W-1:0] prod_q, num_q;

  logic                         dv_valid;
  logic [LANES-1:0][MAG_W-1:0]  quo;
  logic [TAG_W-1:0]             tag_out;
  logic                         flag_d;
  wheel_t [WHEELS-1:0]          w_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flag1_q <= wheels_i[IDX].mag > MAG_W'(lim_i);
      den1_q  <= wheels_i[IDX].mag;
      w1_q    <= wheels_i;
      for (int l = 0; l < LANES; l++) begin
        prod_q[l] <= LNUM_W'(wheels_i[other_wheel(IDX, l)].mag) * LNUM_W'(lim_i);
        // Adding half the divisor makes the quotient round to nearest.
        num_q[l]  <= prod_q[l] + LNUM_W'(den1_q >> 1);
        den2_q[l] <= den1_q;
      end
      flag2_q <= flag1_q;
      w2_q    <= w1_q;
    end
  end

  mwsl_div #(
    .NUM_W (LNUM_W),
    .DEN_W (MAG_W),
    .Q_W   (MAG_W),
    .LANES (LANES),
    .TAG_W (TAG_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_q[1]),
    .num_i   (num_q),
    .den_i   (den2_q),
    .tag_i   ({flag2_q, w2_q}),
    .valid_o (dv_valid),
    .quo_o   (quo),
    .tag_o   (tag_out)
  );

  assign {flag_d, w_d} = tag_out;

  // Signs are kept: the scale factor is the positive ratio limit over magnitude.
  always_comb begin
    wheels_o = w_d;
    if (flag_d) begin
      for (int l = 0; l < LANES; l++) begin
        wheels_o[other_wheel(IDX, l)].mag = quo[l];
      end
      wheels_o[IDX].mag = MAG_W'(lim_i);
    end
  end

  assign valid_o = dv_valid;

endmodule
`default_nettype wire

### hdl/mecanum_wheel_speed_limiter_core.sv
// Top level of the mecanum wheel speed limiter.
// The block turns one body velocity request into four wheel commands and takes
// one request per clock cycle unless the output stalls. It has seven mixing,
// gain and gain scaling stages (the scaling is a shift and a reciprocal multiply),
// then four wheel checks of 32 stages each (a multiply, a rounding add and a
// 30-stage divider), and the output register. All stages advance together while
// the output register is empty or being read, so a stalled output holds the whole
// pipeline. Configuration writes take effect at once and are meant for idle time.
`default_nettype none
module mecanum_wheel_speed_limiter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [mwsl_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [mwsl_pkg::IN_W-1:0]    forward_speed_i,
  input  logic signed [mwsl_pkg::IN_W-1:0]    side_speed_i,
  input  logic signed [mwsl_pkg::IN_W-1:0]    turn_rate_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mwsl_pkg::IN_W-1:0]    front_a_cmd_o,
  output logic signed [mwsl_pkg::IN_W-1:0]    front_b_cmd_o,
  output logic signed [mwsl_pkg::IN_W-1:0]    rear_a_cmd_o,
  output logic signed [mwsl_pkg::IN_W-1:0]    rear_b_cmd_o
);
  import mwsl_pkg::*;

  logic [CFG_W-1:0] speed_gain_q, lever_arm_q;
  logic [LIM_W-1:0] cmd_limit_q;
  logic             en;
  logic             out_valid_q;
  logic signed [IN_W-1:0] fa_q, fb_q, ra_q, rb_q;

  logic                            mix_valid;
  logic [WHEELS-1:0]               mix_neg;
  logic [WHEELS-1:0][MAG_W-1:0]    mix_quo;

  wheel_t [WHEELS-1:0] chain_w [WHEELS+1];
  logic   [WHEELS:0]   chain_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_gain_q <= SPEED_GAIN_RST;
      lever_arm_q  <= LEVER_ARM_RST;
      cmd_limit_q  <= CMD_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SPEED_GAIN: speed_gain_q <= cfg_data_i;
        CFG_LEVER_ARM:  lever_arm_q  <= cfg_data_i;
        CFG_CMD_LIMIT:  cmd_limit_q  <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  mwsl_mix u_mix (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (in_valid_i),
    .forward_speed_i (forward_speed_i),
    .side_speed_i    (side_speed_i),
    .turn_rate_i     (turn_rate_i),
    .speed_gain_i    (speed_gain_q),
    .lever_arm_i     (lever_arm_q),
    .valid_o         (mix_valid),
    .neg_o           (mix_neg),
    .quo_o           (mix_quo)
  );

  for (genvar i = 0; i < WHEELS; i++) begin : g_pack
    assign chain_w[0][i].neg = mix_neg[i];
    assign chain_w[0][i].mag = mix_quo[i];
  end
  assign chain_v[0] = mix_valid;

  for (genvar i = 0; i < WHEELS; i++) begin : g_limit
    mwsl_limit #(
      .IDX (i)
    ) u_limit (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (chain_v[i]),
      .wheels_i (chain_w[i]),
      .lim_i    (cmd_limit_q),
      .valid_o  (chain_v[i+1]),
      .wheels_o (chain_w[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_v[WHEELS];
    end
  end

  // After the last check every magnitude is within the limit, so 16 bits hold it.
  // The front wheels leave negated.
  always_ff @(posedge clk_i) begin
    if (en) begin
      fa_q <= chain_w[WHEELS][0].neg ? $signed(chain_w[WHEELS][0].mag[IN_W-1:0])
                                     : -$signed(chain_w[WHEELS][0].mag[IN_W-1:0]);
      fb_q <= chain_w[WHEELS][1].neg ? $signed(chain_w[WHEELS][1].mag[IN_W-1:0])
                                     : -$signed(chain_w[WHEELS][1].mag[IN_W-1:0]);
      ra_q <= chain_w[WHEELS][2].neg ? -$signed(chain_w[WHEELS][2].mag[IN_W-1:0])
                                     : $signed(chain_w[WHEELS][2].mag[IN_W-1:0]);
      rb_q <= chain_w[WHEELS][3].neg ? -$signed(chain_w[WHEELS][3].mag[IN_W-1:0])
                                     : $signed(chain_w[WHEELS][3].mag[IN_W-1:0]);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign front_a_cmd_o = fa_q;
  assign front_b_cmd_o = fb_q;
  assign rear_a_cmd_o  = ra_q;
  assign rear_b_cmd_o  = rb_q;

endmodule
`default_nettype wire

### tb/mecanum_wheel_speed_limiter_core_test.sv
// Self-checking testbench for the mecanum wheel speed limiter core.
`timescale 1ns / 100ps
`default_nettype none

class wheel_cmd_board;
  typedef struct packed {
    logic signed [15:0] fa;
    logic signed [15:0] fb;
    logic signed [15:0] ra;
    logic signed [15:0] rb;
  } wheel_cmds_t;

  logic [15:0] gain;
  logic [15:0] lever;
  logic [14:0] limit;
  wheel_cmds_t pending[$];
  int errors;
  int checked;

  function new();
    gain = mwsl_pkg::SPEED_GAIN_RST;
    lever = mwsl_pkg::LEVER_ARM_RST;
    limit = mwsl_pkg::CMD_LIMIT_RST;
    errors = 0;
    checked = 0;
  endfunction

  function void set_reg(mwsl_pkg::cfg_idx_e idx, logic [15:0] val);
    case (idx)
      mwsl_pkg::CFG_SPEED_GAIN: gain = val;
      mwsl_pkg::CFG_LEVER_ARM:  lever = val;
      mwsl_pkg::CFG_CMD_LIMIT:  limit = val[14:0];
      default: ;
    endcase
  endfunction

  // Rounds to nearest with ties away from zero.
  function longint rdiv(longint num, longint den);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function void note_request(logic signed [15:0] vx, logic signed [15:0] vy,
                             logic signed [15:0] wr);
    longint w[4];
    longint rot;
    longint mag;
    longint lim;
    wheel_cmds_t e;
    rot = longint'(lever) * longint'(wr);
    lim = longint'(limit);
    w[0] = 1000 * (longint'(vx) + vy) + rot;
    w[1] = 1000 * (longint'(vx) - vy) - rot;
    w[2] = 1000 * (longint'(vx) - vy) + rot;
    w[3] = 1000 * (longint'(vx) + vy) - rot;
    for (int i = 0; i < 4; i++) w[i] = rdiv(w[i] * longint'(gain), 256000);
    for (int i = 0; i < 4; i++) begin
      mag = (w[i] < 0) ? -w[i] : w[i];
      if (mag > lim) begin
        for (int j = 0; j < 4; j++)
          if (j != i) w[j] = rdiv(w[j] * lim, mag);
        w[i] = (w[i] < 0) ? -lim : lim;
      end
    end
    e.fa = 16'(-w[0]);
    e.fb = 16'(-w[1]);
    e.ra = 16'(w[2]);
    e.rb = 16'(w[3]);
    pending.push_back(e);
  endfunction

  function void check_result(logic signed [15:0] fa, logic signed [15:0] fb,
                             logic signed [15:0] ra, logic signed [15:0] rb);
    wheel_cmds_t e;
    if (pending.size() == 0) begin
      $error("result with no request waiting: %0d %0d %0d %0d", fa, fb, ra, rb);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (fa !== e.fa) begin $error("front_a_cmd exp %0d got %0d", e.fa, fa); errors++; end
    if (fb !== e.fb) begin $error("front_b_cmd exp %0d got %0d", e.fb, fb); errors++; end
    if (ra !== e.ra) begin $error("rear_a_cmd exp %0d got %0d", e.ra, ra); errors++; end
    if (rb !== e.rb) begin $error("rear_b_cmd exp %0d got %0d", e.rb, rb); errors++; end
  endfunction
endclass

module mecanum_wheel_speed_limiter_core_test;
  import mwsl_pkg::*;

  localparam int LATENCY = 136;
  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] forward_speed_i = '0;
  logic signed [15:0] side_speed_i = '0;
  logic signed [15:0] turn_rate_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] front_a_cmd_o, front_b_cmd_o, rear_a_cmd_o, rear_b_cmd_o;

  wheel_cmd_board board = new();
  int send_idle = 0;
  int recv_idle = 0;
  int quiet = 0;
  int n_sent = 0;
  bit timed_out = 0;

  mecanum_wheel_speed_limiter_core DUT (.*);

  initial forever #5 clk_i = ~clk_i;

  // Receiver side: random stalls, checks every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        board.check_result(front_a_cmd_o, front_b_cmd_o, rear_a_cmd_o, rear_b_cmd_o);
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
    else if (rst_ni) quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The enable drops before the next write may raise it again.
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    board.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until the pipeline is empty so a register write cannot hit a request.
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Holds the request until it is accepted; valid stays high across requests unless send_idle draws a gap.
  task automatic send(logic signed [15:0] vx, logic signed [15:0] vy,
                      logic signed [15:0] wr);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    forward_speed_i <= vx;
    side_speed_i <= vy;
    turn_rate_i <= wr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_request(vx, vy, wr);
    n_sent++;
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_run(int count);
    for (int k = 0; k < count; k++) send(pick16(), pick16(), pick16());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, zeros, single axes and limiting in each wheel.
    send_idle = 0; recv_idle = 0;
    send(0, 0, 0);
    send(16'sh7FFF, 0, 0);
    send(16'sh8000, 0, 0);
    send(0, 16'sh7FFF, 0);
    send(0, 16'sh8000, 0);
    send(0, 0, 16'sh7FFF);
    send(0, 0, 16'sh8000);
    send(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send(16'sh8000, 16'sh8000, 16'sh8000);
    send(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send(16'sh8000, 16'sh7FFF, 16'sh8000);
    send(100, -50, 30);
    send(-1, 1, -1);
    stop_sending();
    drain();
    write_reg(CFG_CMD_LIMIT, 16'h0000);
    send(1000, 200, -300);
    send(16'sh8000, 16'sh7FFF, 16'sh7FFF);
    stop_sending();
    drain();
    write_reg(CFG_SPEED_GAIN, 16'h0000);
    write_reg(CFG_CMD_LIMIT, 16'h7FFF);
    send(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    stop_sending();
    drain();
    write_reg(CFG_SPEED_GAIN, 16'hFFFF);
    write_reg(CFG_LEVER_ARM, 16'hFFFF);
    send(16'sh8000, 16'sh8000, 16'sh7FFF);
    send(3, -2, 1);
    stop_sending();
    drain();

    // Random phases across several register settings.
    for (int p = 0; p < 6; p++) begin
      case (p % 3)
        0: begin send_idle = 28; recv_idle = 69; end
        1: begin send_idle = 69; recv_idle = 28; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      write_reg(CFG_SPEED_GAIN, (p == 0) ? SPEED_GAIN_RST : 16'($urandom_range(65535)));
      write_reg(CFG_LEVER_ARM, (p == 1) ? 16'h0000 : 16'($urandom_range(2000)));
      write_reg(CFG_CMD_LIMIT, (p == 2) ? 16'h0001 : 16'($urandom_range(32767)));
      random_run(55);
      // Sender holds off until the pipeline has delivered everything.
      stop_sending();
      while (board.pending.size() != 0) @(posedge clk_i);
      random_run(55);
      stop_sending();
      drain();
    end

    $display("Sent %0d requests over extreme and random gain, lever and limit settings;",
             n_sent);
    $display("checked %0d wheel command results under mixed handshake stalls.",
             board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
hdl/mwsl_pkg.sv
hdl/mwsl_mix.sv
hdl/mwsl_div.sv
hdl/mwsl_limit.sv
hdl/mecanum_wheel_speed_limiter_core.sv
tb/mecanum_wheel_speed_limiter_core_test.sv
